// File: hw/rtl/fnvtm_pkg.sv
// ----------------------------------------------------------------------------
// fnvtm_pkg: shared types and constants for the FNV-1a 64 target match core
// Hash constants, config register indexes, the pipeline transaction type and
// the single-round hash function used by every round stage.
// ----------------------------------------------------------------------------
package fnvtm_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned NUM_BYTES = WORD_W / BYTE_W;
	localparam int unsigned COUNT_W   = 4;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned MAX_TARGETS     = 7;
	localparam int unsigned NUM_TARGETS_DEF = 7;

	// Offset basis; the prime 0x100000001B3 is applied as (x << 40) + x * 0x1B3
	localparam logic [WORD_W-1:0] OFFSET_BASIS    = 64'hCBF2_9CE4_8422_2325;
	localparam logic [8:0]        FNV_PRIME_LO    = 9'h1B3;
	localparam int unsigned       FNV_PRIME_SHIFT = 40;

	localparam logic [COUNT_W-1:0] BYTE_COUNT_RESET = 4'd8;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_4   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_5   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_6   = 3'd7;

	typedef logic [MAX_TARGETS-1:0][WORD_W-1:0] target_array_t;

	// One transaction moving through the round stages
	typedef struct packed {
		logic              vld;
		logic [WORD_W-1:0] hash;
		logic [WORD_W-1:0] cand;
	} pipe_t;

	// XOR one byte in, then multiply by the FNV prime modulo 2^64
	function automatic logic [WORD_W-1:0] fnv_round(
		input logic [WORD_W-1:0] h,
		input logic [BYTE_W-1:0] b
	);
		logic [WORD_W-1:0] x;
		x = h ^ {{(WORD_W-BYTE_W){1'b0}}, b};
		return (x << FNV_PRIME_SHIFT) + (x * {{(WORD_W-9){1'b0}}, FNV_PRIME_LO});
	endfunction

endpackage

// File: hw/rtl/fnvtm_round.sv
// ----------------------------------------------------------------------------
// fnvtm_round: one FNV-1a round stage
// Hashes one fixed byte of the candidate when the byte count covers it,
// otherwise passes the running hash through. Registered, with its own ready.
// ----------------------------------------------------------------------------
module fnvtm_round #(
	parameter int unsigned STAGE = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fnvtm_pkg::pipe_t                 d,
	output logic                             ready_up,
	input  logic [fnvtm_pkg::COUNT_W-1:0]    n_bytes,
	output fnvtm_pkg::pipe_t                 q,
	input  logic                             ready_dn
);
	import fnvtm_pkg::*;

	localparam int unsigned BYTE_IDX = NUM_BYTES - 1 - STAGE;

	logic              vld_s;
	logic [WORD_W-1:0] hash_s;
	logic [WORD_W-1:0] cand_s;
	logic              active;
	logic [WORD_W-1:0] hash_nxt;

	assign ready_up = !vld_s || ready_dn;
	assign active   = n_bytes > COUNT_W'(BYTE_IDX);
	assign hash_nxt = active ? fnv_round(d.hash, d.cand[BYTE_IDX*BYTE_W +: BYTE_W]) : d.hash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (ready_up) begin
			vld_s <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && d.vld) begin
			hash_s <= hash_nxt;
			cand_s <= d.cand;
		end
	end

	assign q = '{vld: vld_s, hash: hash_s, cand: cand_s};

endmodule

// File: hw/rtl/fnvtm_match.sv
// ----------------------------------------------------------------------------
// fnvtm_match: target compare and output register
// Compares the finished hash against the enabled targets and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module fnvtm_match #(
	parameter int unsigned NUM_TARGETS = fnvtm_pkg::NUM_TARGETS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fnvtm_pkg::pipe_t                    d,
	output logic                                ready_up,
	input  fnvtm_pkg::target_array_t            targets,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fnvtm_pkg::WORD_W-1:0]        hash_value,
	output logic [fnvtm_pkg::MAX_TARGETS-1:0]   match_mask
);
	import fnvtm_pkg::*;

	logic                   vld_s9;
	logic [WORD_W-1:0]      hash_s9;
	logic [MAX_TARGETS-1:0] mask_s9;
	logic [MAX_TARGETS-1:0] mask_nxt;

	assign ready_up = !vld_s9 || !out_stall;

	always_comb begin
		mask_nxt = '0;
		for (int i = 0; i < NUM_TARGETS; i++) begin
			mask_nxt[i] = (d.hash == targets[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (ready_up) begin
			vld_s9 <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && d.vld) begin
			hash_s9 <= d.hash;
			mask_s9 <= mask_nxt;
		end
	end

	assign out_valid  = vld_s9;
	assign hash_value = hash_s9;
	assign match_mask = mask_s9;

endmodule

// File: hw/rtl/fnv1a64_be_value_target_match_core.sv
// ----------------------------------------------------------------------------
// fnv1a64_be_value_target_match_core: FNV-1a 64 preimage search core
// Hashes the low byte_count bytes of each candidate, most significant byte
// first, and flags which of the configured target hashes it hits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / candidate): one candidate per
//   transaction. Output channel (out_valid / out_stall / hash_value /
//   match_mask): exactly one result per candidate, in order.
//   An accepted input reaches out_valid through eight round stages (one
//   FNV-1a byte round each: XOR, then multiply by the prime as a 40-bit
//   shift plus a 9-bit constant multiply) and one compare/output stage.
//   Throughput is one transaction per cycle while out_stall is low.
//   Rounds for bytes above byte_count pass the hash through, so a short
//   candidate goes through the same stages. byte_count 0 yields the offset
//   basis; counts 9..15 hash all eight bytes.
//   Each stage has its own ready, so a stall at the output only backs up
//   full stages; bubbles keep filling and no transaction is lost or
//   repeated. in_stall rises only once every stage is occupied.
//   Reset clears all stage valid bits, sets byte_count to 8 and the
//   targets to 0. Write the config port only while the pipeline is empty.
// ----------------------------------------------------------------------------
module fnv1a64_be_value_target_match_core #(
	parameter int unsigned NUM_TARGETS = fnvtm_pkg::NUM_TARGETS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_wr_en,
	input  logic [fnvtm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fnvtm_pkg::WORD_W-1:0]        cfg_wdata,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [fnvtm_pkg::WORD_W-1:0]        candidate,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fnvtm_pkg::WORD_W-1:0]        hash_value,
	output logic [fnvtm_pkg::MAX_TARGETS-1:0]   match_mask
);
	import fnvtm_pkg::*;

	logic [COUNT_W-1:0] byte_count_q;
	target_array_t      target_q;
	logic [COUNT_W-1:0] n_bytes;

	pipe_t pipe  [0:NUM_BYTES];
	logic  ready [0:NUM_BYTES];

	// Config registers: index 0 is the byte count, the rest are targets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= BYTE_COUNT_RESET;
			target_q     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_BYTE_COUNT: byte_count_q <= cfg_wdata[COUNT_W-1:0];
				CFG_TARGET_0,
				CFG_TARGET_1,
				CFG_TARGET_2,
				CFG_TARGET_3,
				CFG_TARGET_4,
				CFG_TARGET_5,
				CFG_TARGET_6:   target_q[cfg_index - CFG_TARGET_0] <= cfg_wdata;
				default:        byte_count_q <= byte_count_q;
			endcase
		end
	end

	// Saturate the byte count at a full word
	assign n_bytes = (byte_count_q > COUNT_W'(NUM_BYTES)) ? COUNT_W'(NUM_BYTES)
	                                                      : byte_count_q;

	// Enter the pipe with the offset basis as the running hash
	assign pipe[0]  = '{vld: in_valid, hash: OFFSET_BASIS, cand: candidate};
	assign in_stall = !ready[0];

	// One round stage per byte, most significant byte first
	for (genvar k = 0; k < NUM_BYTES; k++) begin : g_round
		fnvtm_round #(
			.STAGE (k)
		) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.d        (pipe[k]),
			.ready_up (ready[k]),
			.n_bytes  (n_bytes),
			.q        (pipe[k+1]),
			.ready_dn (ready[k+1])
		);
	end

	// Compare against the targets and hold the result for the receiver
	fnvtm_match #(
		.NUM_TARGETS (NUM_TARGETS)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.d          (pipe[NUM_BYTES]),
		.ready_up   (ready[NUM_BYTES]),
		.targets    (target_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.match_mask (match_mask)
	);

endmodule

// File: hw/rtl/fnvtm_checker.sv
// ----------------------------------------------------------------------------
// fnvtm_checker: port-level assertions for the target match core
// Shadows the config writes and checks results, stall behavior and output
// hold against what the ports show.
// ----------------------------------------------------------------------------
module fnvtm_checker #(
	parameter int unsigned NUM_TARGETS = fnvtm_pkg::NUM_TARGETS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fnvtm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fnvtm_pkg::WORD_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [fnvtm_pkg::WORD_W-1:0]        hash_value,
	input  logic [fnvtm_pkg::MAX_TARGETS-1:0]   match_mask
);
	import fnvtm_pkg::*;

	logic [COUNT_W-1:0]     bc_q;
	target_array_t          tgt_q;
	logic [MAX_TARGETS-1:0] exp_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q  <= BYTE_COUNT_RESET;
			tgt_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_BYTE_COUNT) begin
				bc_q <= cfg_wdata[COUNT_W-1:0];
			end else begin
				tgt_q[cfg_index - CFG_TARGET_0] <= cfg_wdata;
			end
		end
	end

	always_comb begin
		exp_mask = '0;
		for (int i = 0; i < NUM_TARGETS; i++) begin
			exp_mask[i] = (hash_value == tgt_q[i]);
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_value) && $stable(match_mask))
		else $error("result changed while stalled");

	// Mask agrees with the reported hash and the written targets
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_mask == exp_mask)
		else $error("match_mask disagrees with hash_value and targets");

	// Zero byte count leaves the offset basis
	a_basis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bc_q == '0) |-> hash_value == OFFSET_BASIS)
		else $error("zero byte count did not give the offset basis");

	// Input never backs up while the output side is moving or empty
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled while output was free");

	// An offered input is only stalled while a result is held at the output
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind fnv1a64_be_value_target_match_core fnvtm_checker #(
	.NUM_TARGETS (NUM_TARGETS)
) u_fnvtm_checker (.*);

// File: verif/fnvtm_scoreboard.sv
// ----------------------------------------------------------------------------
// fnvtm_tb_pkg: scoreboard for the FNV-1a 64 target match core
// Keeps a shadow of the config registers, predicts hash and match mask for
// each accepted candidate and checks the results in order.
// ----------------------------------------------------------------------------
package fnvtm_tb_pkg;
	import fnvtm_pkg::*;

	localparam logic [WORD_W-1:0] PRIME_64   = 64'h0000_0100_0000_01B3;

	typedef struct packed {
		logic [WORD_W-1:0]      hash;
		logic [MAX_TARGETS-1:0] mask;
	} match_result_t;

	class match_scoreboard;
		int unsigned         num_targets = NUM_TARGETS_DEF;
		logic [COUNT_W-1:0]  byte_count = BYTE_COUNT_RESET;
		logic [WORD_W-1:0]   targets [MAX_TARGETS] = '{default: '0};
		match_result_t       expected_q [$];
		int unsigned         noted;
		int unsigned         checked;
		int unsigned         hits;
		int unsigned         errors;

		// FNV-1a over the low nbytes of value, most significant byte first
		function logic [WORD_W-1:0] fnv_hash(input logic [WORD_W-1:0] value,
				input logic [COUNT_W-1:0] nbytes);
			logic [WORD_W-1:0] h;
			int                n;
			h = OFFSET_BASIS;
			n = (nbytes > NUM_BYTES) ? NUM_BYTES : nbytes;
			for (int b = n; b > 0; b--) begin
				h ^= {{(WORD_W-BYTE_W){1'b0}}, value[(b-1)*BYTE_W +: BYTE_W]};
				h = h * PRIME_64;
			end
			return h;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
			if (idx == CFG_BYTE_COUNT) begin
				byte_count = data[COUNT_W-1:0];
			end else begin
				targets[idx - CFG_TARGET_0] = data;
			end
		endfunction

		function void flag(input string msg);
			errors++;
			$error("%s", msg);
		endfunction

		function void note_candidate(input logic [WORD_W-1:0] cand);
			match_result_t r;
			r.hash = fnv_hash(cand, byte_count);
			r.mask = '0;
			for (int i = 0; i < num_targets; i++) begin
				if (r.hash == targets[i]) begin
					r.mask[i] = 1'b1;
				end
			end
			expected_q.push_back(r);
			noted++;
		endfunction

		function void check_result(input logic [WORD_W-1:0] hash,
				input logic [MAX_TARGETS-1:0] mask);
			match_result_t e;
			checked++;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with nothing expected: hash_value %h match_mask %b",
					hash, mask));
				return;
			end
			e = expected_q.pop_front();
			if (e.mask != 0) begin
				hits++;
			end
			if (hash !== e.hash) begin
				flag($sformatf("hash_value: expected %h, actual %h", e.hash, hash));
			end
			if (mask !== e.mask) begin
				flag($sformatf("match_mask: expected %b, actual %b", e.mask, mask));
			end
		endfunction
	endclass

endpackage

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the FNV-1a 64 target match core
// Drives candidates through the valid/stall input channel under a range of
// byte counts and target sets, with random idling on both sides, and checks
// every hash and match mask against a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import fnvtm_pkg::*;
	import fnvtm_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_PCT      = 34;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned ITEMS_PER_SET = 82;
	localparam int unsigned NUM_SETS      = 9;
	localparam int unsigned LIMIT_CYCLES  = 200000;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index  = CFG_BYTE_COUNT;
	logic [WORD_W-1:0]      cfg_wdata  = '0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic [WORD_W-1:0]      candidate  = '0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [WORD_W-1:0]      hash_value;
	logic [MAX_TARGETS-1:0] match_mask;

	bit                     src_idle   = 1'b1;
	bit                     sink_stall = 1'b1;
	int unsigned            cycle_count;
	int unsigned            settings;
	match_scoreboard        sb;

	fnv1a64_be_value_target_match_core #(
		.NUM_TARGETS(NUM_TARGETS_DEF)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.candidate  (candidate),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.match_mask (match_mask)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, sb.expected_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Output side: check the transaction that completed at this edge, then
	// decide the stall for the next cycle. Values read here are pre-edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(hash_value, match_mask);
		end
		out_stall <= sink_stall && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Present one candidate, idling first at random, and hold it until the
	// core takes it. valid stays high between back-to-back transactions.
	task automatic send_candidate(input logic [WORD_W-1:0] value);
		while (src_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		candidate <= value;
		do @(posedge clk); while (in_stall);
		sb.note_candidate(value);
	endtask

	// Drop valid and let the pipeline empty before touching the registers
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller lowers the write enable after a batch
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Program the byte count and all seven targets. Junk goes into the
	// unused upper bits of the byte count word: only the low nibble counts.
	task automatic program_regs(input logic [COUNT_W-1:0] bc,
			input logic [WORD_W-1:0] tg [MAX_TARGETS]);
		logic [WORD_W-1:0] word;
		word = {$urandom, $urandom};
		word[COUNT_W-1:0] = bc;
		put_reg(CFG_BYTE_COUNT, word);
		for (int i = 0; i < MAX_TARGETS; i++) begin
			put_reg(CFG_IDX_W'(CFG_TARGET_0 + i), tg[i]);
		end
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	initial begin
		logic [WORD_W-1:0]  tg [MAX_TARGETS];
		logic [WORD_W-1:0]  pool [MAX_TARGETS];
		logic [WORD_W-1:0]  keep;
		logic [WORD_W-1:0]  cand;
		logic [COUNT_W-1:0] bc;
		int unsigned        pick;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset config: all eight bytes hashed, every target zero
		send_candidate('0);
		send_candidate('1);
		send_candidate(64'h1);
		send_candidate(64'h8000_0000_0000_0000);
		send_candidate(64'h0123_4567_89AB_CDEF);
		send_candidate(64'hFF00_FF00_FF00_FF00);

		// Byte count zero: every hash is the offset basis, so the targets
		// holding it all fire; target extremes sit next to them
		settle();
		tg[0] = OFFSET_BASIS;
		tg[1] = '0;
		tg[2] = '1;
		tg[3] = OFFSET_BASIS;
		tg[4] = {$urandom, $urandom};
		tg[5] = OFFSET_BASIS;
		tg[6] = {$urandom, $urandom};
		program_regs(4'd0, tg);
		send_candidate('0);
		send_candidate('1);
		send_candidate({$urandom, $urandom});
		send_candidate({$urandom, $urandom});

		// Byte count fifteen saturates to eight; target 6 duplicates target 0
		settle();
		for (int i = 0; i < MAX_TARGETS; i++) begin
			pool[i] = {$urandom, $urandom};
			tg[i]   = sb.fnv_hash(pool[i], 4'd8);
		end
		tg[6] = tg[0];
		program_regs(4'd15, tg);
		for (int i = 0; i < MAX_TARGETS - 1; i++) begin
			send_candidate(pool[i]);
		end

		// Random sets: half the candidates are preimages of a target with
		// the ignored upper bytes scrambled, the rest are noise
		for (int p = 0; p < NUM_SETS; p++) begin
			settle();
			// Set 4 runs with no idling at all; sets 2 and 6 idle one side only
			src_idle   = (p != 4) && (p != 6);
			sink_stall = (p != 4) && (p != 2);
			pick = $urandom_range(0, 9);
			if (p == 0) begin
				bc = 4'd1;
			end else if (p == 1) begin
				bc = 4'd8;
			end else if (pick == 0) begin
				bc = 4'd0;
			end else if (pick == 1) begin
				bc = COUNT_W'($urandom_range(9, 15));
			end else begin
				bc = COUNT_W'($urandom_range(1, 8));
			end
			for (int i = 0; i < MAX_TARGETS; i++) begin
				pool[i] = {$urandom, $urandom};
			end
			for (int i = 0; i < MAX_TARGETS; i++) begin
				pick = $urandom_range(0, 9);
				if (pick <= 5) begin
					tg[i] = sb.fnv_hash(pool[$urandom_range(0, MAX_TARGETS - 1)], bc);
				end else if (pick == 6) begin
					tg[i] = '0;
				end else if (pick == 7) begin
					tg[i] = '1;
				end else if (pick == 8 || i == 0) begin
					tg[i] = {$urandom, $urandom};
				end else begin
					tg[i] = tg[i-1];
				end
			end
			program_regs(bc, tg);
			if (bc == 0) begin
				keep = '0;
			end else if (bc >= NUM_BYTES) begin
				keep = '1;
			end else begin
				keep = (64'd1 << (BYTE_W * bc)) - 64'd1;
			end
			repeat (ITEMS_PER_SET) begin
				if ($urandom_range(0, 1)) begin
					cand = (pool[$urandom_range(0, MAX_TARGETS - 1)] & keep)
						| ({$urandom, $urandom} & ~keep);
				end else begin
					cand = {$urandom, $urandom};
				end
				send_candidate(cand);
			end
		end

		settle();
		if (sb.expected_q.size() != 0) begin
			sb.flag($sformatf("%0d results never arrived", sb.expected_q.size()));
		end
		$display("Covered %0d candidates across %0d register settings, %s",
			sb.noted, settings + 1, "with zero, partial, full and saturated byte counts");
		$display("Checked %0d results, %0d with a target hit, %0d mismatches",
			sb.checked, sb.hits, sb.errors);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
